>>> sv/rset_pkg.sv
// shared widths, status codes and the table entry type for the ratio-sorted entry table
package rset_pkg;

    // default table depth
    localparam int DEPTH_DEF = 16;

    // field widths
    localparam int FUNC_W   = 1;
    localparam int ID_W     = 16;
    localparam int WEIGHT_W = 16;
    localparam int SKILL_W  = 16;
    localparam int RATIO_W  = 32;
    localparam int STATUS_W = 3;
    localparam int RANK_W   = 4;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ZERO_WT   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;

    // one table slot
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
        logic [SKILL_W-1:0]  skill;
        logic [RATIO_W-1:0]  ratio;
    } t_entry;

endpackage

>>> sv/ratio_sorted_entry_table.sv
// ratio-sorted entry table: serial divider, slot walk and shift under one sequencer
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  request | in        | i_valid / o_stall  | i_func i_entry_id i_weight i_skill
//  result  | out       | o_valid / i_stall  | o_status o_found_id o_found_weight
//          |           |                    | o_found_skill o_found_ratio o_rank
//
// insert: accept, a divide step per quotient bit, read and check per slot walked plus a
//   tail step, read and write per slot shifted, shift end, write, hand-off; search: accept,
//   read and check per slot walked, a step on a miss, hand-off; refusals: accept, hand-off
// o_stall is low only in the idle state; the hand-off waits while i_stall holds the result
//   in the output register, and no new request is taken meanwhile
// synchronous active-low reset clears the fill count, the sequencer and o_valid only
module ratio_sorted_entry_table #(
    parameter int DEPTH = rset_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [rset_pkg::FUNC_W-1:0]   i_func,
    input  logic [rset_pkg::ID_W-1:0]     i_entry_id,
    input  logic [rset_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [rset_pkg::SKILL_W-1:0]  i_skill,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rset_pkg::STATUS_W-1:0] o_status,
    output logic [rset_pkg::ID_W-1:0]     o_found_id,
    output logic [rset_pkg::WEIGHT_W-1:0] o_found_weight,
    output logic [rset_pkg::SKILL_W-1:0]  o_found_skill,
    output logic [rset_pkg::RATIO_W-1:0]  o_found_ratio,
    output logic [rset_pkg::RANK_W-1:0]   o_rank
);
    import rset_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int DIV_STEPS = RATIO_W;
    localparam int DCW = $clog2(DIV_STEPS);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_PRD  = 4'd2;
    localparam logic [3:0] S_PCHK = 4'd3;
    localparam logic [3:0] S_SHRD = 4'd4;
    localparam logic [3:0] S_SHWR = 4'd5;
    localparam logic [3:0] S_WR   = 4'd6;
    localparam logic [3:0] S_SRD  = 4'd7;
    localparam logic [3:0] S_SCHK = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    logic [3:0]          r_state;
    logic [CW-1:0]       r_fill;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_pos;
    logic [DCW-1:0]      r_cnt;

    // latched request
    logic [ID_W-1:0]     r_id;
    logic [WEIGHT_W-1:0] r_w;
    logic [SKILL_W-1:0]  r_s;

    // divider: remainder and quotient, dividend shifts out of the quotient register
    logic [WEIGHT_W-1:0] r_rem;
    logic [RATIO_W-1:0]  r_quo;

    // staged result
    logic [STATUS_W-1:0] r_res_status;
    t_entry              r_res_entry;
    logic [RANK_W-1:0]   r_res_rank;

    // output register
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    t_entry              r_o_entry;
    logic [RANK_W-1:0]   r_o_rank;

    // slot memory, one write and one registered read port
    t_entry              r_mem [DEPTH];
    t_entry              r_rd;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_entry              mem_wdata;

    logic                in_acc;
    logic                out_free;
    logic [WEIGHT_W:0]   div_trial;
    logic                div_ge;
    logic [WEIGHT_W-1:0] div_rem;
    logic                pos_stop;
    logic [CW-1:0]       idx_dec;
    t_entry              new_entry;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;
    assign idx_dec  = r_idx - CW'(1);

    // one restoring divide step
    assign div_trial = {r_rem, r_quo[RATIO_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_w});
    assign div_rem   = div_ge ? WEIGHT_W'(div_trial - {1'b0, r_w}) : div_trial[WEIGHT_W-1:0];

    // head takes only a strictly greater key, later slots also an equal one
    assign pos_stop = (r_idx == '0) ? (r_quo > r_rd.ratio) : (r_quo >= r_rd.ratio);

    assign new_entry = '{id: r_id, weight: r_w, skill: r_s, ratio: r_quo};

    // memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_idx[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_wdata = r_rd;
        case (r_state)
            S_PRD, S_SRD: begin
                mem_re = (r_idx != r_fill);
            end
            S_SHRD: begin
                mem_re    = (r_idx != r_pos);
                mem_raddr = idx_dec[AW-1:0];
            end
            S_SHWR: begin
                mem_we = 1'b1;
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = new_entry;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_id  <= i_entry_id;
                        r_w   <= i_weight;
                        r_s   <= i_skill;
                        r_idx <= '0;
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_quo <= {i_skill, {(RATIO_W-SKILL_W){1'b0}}};
                        r_res_entry <= '0;
                        r_res_rank  <= '0;
                        if (i_func == FUNC_SEARCH) begin
                            r_state <= S_SRD;
                        end else if (r_fill == CW'(DEPTH)) begin
                            r_res_status <= STAT_FULL;
                            r_state      <= S_EMIT;
                        end else if (i_weight == '0) begin
                            r_res_status <= STAT_ZERO_WT;
                            r_state      <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= div_rem;
                    r_quo <= {r_quo[RATIO_W-2:0], div_ge};
                    r_cnt <= r_cnt + DCW'(1);
                    if (r_cnt == DCW'(DIV_STEPS - 1)) begin
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    if (r_idx == r_fill) begin
                        r_pos   <= r_idx;
                        r_idx   <= r_fill;
                        r_state <= S_SHRD;
                    end else begin
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    if (pos_stop) begin
                        r_pos   <= r_idx;
                        r_idx   <= r_fill;
                        r_state <= S_SHRD;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_PRD;
                    end
                end
                S_SHRD: begin
                    if (r_idx == r_pos) begin
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_idx   <= idx_dec;
                    r_state <= S_SHRD;
                end
                S_WR: begin
                    r_fill       <= r_fill + CW'(1);
                    r_res_status <= STAT_INSERTED;
                    r_res_entry  <= new_entry;
                    r_res_rank   <= RANK_W'(r_pos);
                    r_state      <= S_EMIT;
                end
                S_SRD: begin
                    if (r_idx == r_fill) begin
                        r_res_status <= STAT_NOT_FOUND;
                        r_state      <= S_EMIT;
                    end else begin
                        r_state <= S_SCHK;
                    end
                end
                S_SCHK: begin
                    if (r_rd.id == r_id) begin
                        r_res_status <= STAT_FOUND;
                        r_res_entry  <= r_rd;
                        r_res_rank   <= RANK_W'(r_idx);
                        r_state      <= S_EMIT;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_o_valid  <= 1'b1;
            r_o_status <= r_res_status;
            r_o_entry  <= r_res_entry;
            r_o_rank   <= r_res_rank;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_found_id     = r_o_entry.id;
    assign o_found_weight = r_o_entry.weight;
    assign o_found_skill  = r_o_entry.skill;
    assign o_found_ratio  = r_o_entry.ratio;
    assign o_rank         = r_o_rank;

`ifndef SYNTH
    // fill count never passes the table depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count above depth");

    // fill count grows by one after the insert write and changes nowhere else
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |=> r_fill == $past(r_fill) + CW'(1))
        else $error("fill count not bumped on insert");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_WR |=> $stable(r_fill))
        else $error("fill count changed outside insert");

    // the shift walk never goes below the insert position
    a_shift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHRD || r_state == S_SHWR |-> r_idx >= r_pos)
        else $error("shift index below insert position");

    // remainder ends below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt == DCW'(DIV_STEPS - 1) |=> r_rem < r_w)
        else $error("divider remainder not below divisor");
`endif

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the ratio-sorted entry table
`timescale 1ns / 100ps

module tb_top;
    import rset_pkg::*;

    localparam int TBL_DEPTH   = DEPTH_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 120;
    localparam int MAX_GAP     = 40;
    localparam int MAX_REPORTS = 10;

    // one result as the block presents it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [WEIGHT_W-1:0] weight;
        logic [SKILL_W-1:0]  skill;
        logic [RATIO_W-1:0]  ratio;
        logic [RANK_W-1:0]   rank;
    } t_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [FUNC_W-1:0]   i_func = FUNC_INSERT;
    logic [ID_W-1:0]     i_entry_id = '0;
    logic [WEIGHT_W-1:0] i_weight = '0;
    logic [SKILL_W-1:0]  i_skill = '0;
    logic                o_valid;
    logic                i_stall = 1'b1;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_found_id;
    logic [WEIGHT_W-1:0] o_found_weight;
    logic [SKILL_W-1:0]  o_found_skill;
    logic [RATIO_W-1:0]  o_found_ratio;
    logic [RANK_W-1:0]   o_rank;

    // shadow copy of the sorted table
    t_entry  shadow_slot [TBL_DEPTH];
    int      shadow_fill = 0;
    t_result pending_results [$];

    int send_idle_pct = 25;
    int recv_idle_pct = 55;
    int n_mismatch = 0;
    int n_checked = 0;
    int n_inserted = 0;
    int n_full = 0;
    int n_zero_wt = 0;
    int n_hit = 0;
    int n_miss = 0;
    int quiet_cycles = 0;
    t_result got_result;
    t_result want_result;

    ratio_sorted_entry_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_entry_id     (i_entry_id),
        .i_weight       (i_weight),
        .i_skill        (i_skill),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_found_id     (o_found_id),
        .o_found_weight (o_found_weight),
        .o_found_skill  (o_found_skill),
        .o_found_ratio  (o_found_ratio),
        .o_rank         (o_rank)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one request to the shadow table and return the result it must give
    function automatic t_result table_outcome(input logic [FUNC_W-1:0] func,
                                              input logic [ID_W-1:0] id,
                                              input logic [WEIGHT_W-1:0] w,
                                              input logic [SKILL_W-1:0] s);
        t_result          r;
        int               pos;
        logic [RATIO_W-1:0] key;
        logic             hit;
        r = '0;
        hit = 1'b0;
        if (func == FUNC_INSERT) begin
            if (shadow_fill >= TBL_DEPTH) begin
                // full beats zero weight
                r.status = STAT_FULL;
                n_full++;
            end else if (w == '0) begin
                r.status = STAT_ZERO_WT;
                n_zero_wt++;
            end else begin
                key = {s, 16'h0000} / {16'h0000, w};
                // strictly greater takes the head, else first later slot not greater
                if (shadow_fill == 0 || key > shadow_slot[0].ratio) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < shadow_fill && key < shadow_slot[pos].ratio) pos++;
                end
                for (int i = shadow_fill; i > pos; i--) shadow_slot[i] = shadow_slot[i-1];
                shadow_slot[pos] = '{id: id, weight: w, skill: s, ratio: key};
                shadow_fill++;
                r = {STAT_INSERTED, id, w, s, key, pos[RANK_W-1:0]};
                n_inserted++;
            end
        end else begin
            r.status = STAT_NOT_FOUND;
            for (int i = 0; i < shadow_fill; i++) begin
                if (!hit && shadow_slot[i].id == id) begin
                    hit = 1'b1;
                    r = {STAT_FOUND, shadow_slot[i].id, shadow_slot[i].weight,
                         shadow_slot[i].skill, shadow_slot[i].ratio, i[RANK_W-1:0]};
                end
            end
            if (hit) n_hit++;
            else n_miss++;
        end
        return r;
    endfunction

    // present one request, wait for it to be taken, record its result
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] id,
                                input logic [WEIGHT_W-1:0] w, input logic [SKILL_W-1:0] s);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        i_valid    <= 1'b1;
        i_func     <= func;
        i_entry_id <= id;
        i_weight   <= w;
        i_skill    <= s;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        pending_results.push_back(table_outcome(func, id, w, s));
    endtask

    // hold off new requests until every result is back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // random field values, biased toward colliding keys and stored ids
    function automatic logic [ID_W-1:0] pick_id(input int stored_pct);
        if (shadow_fill > 0 && $urandom_range(99) < stored_pct)
            return shadow_slot[$urandom_range(shadow_fill - 1)].id;
        return ID_W'($urandom);
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        logic [WEIGHT_W-1:0] few [5] = '{16'h0001, 16'h0002, 16'h0003, 16'h0100, 16'hFFFF};
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 40) return few[$urandom_range(4)];
        return WEIGHT_W'($urandom);
    endfunction

    function automatic logic [SKILL_W-1:0] pick_skill();
        logic [SKILL_W-1:0] few [6] = '{16'h0000, 16'h0001, 16'h0002, 16'h0100, 16'h0200,
                                        16'hFFFF};
        if ($urandom_range(99) < 35) return few[$urandom_range(5)];
        return SKILL_W'($urandom);
    endfunction

    // searches and refused inserts on an empty table
    task automatic test_empty_table();
        send_request(FUNC_SEARCH, 16'h1234, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_request(FUNC_INSERT, 16'h0000, 16'h0000, 16'h0000);
        send_request(FUNC_SEARCH, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // key extremes, ties with the head and the tail, duplicate ids
    task automatic test_key_order();
        send_request(FUNC_INSERT, 16'h0000, 16'h0001, 16'hFFFF);
        send_request(FUNC_INSERT, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_request(FUNC_INSERT, 16'hA5A5, 16'h0001, 16'hFFFF);
        send_request(FUNC_INSERT, 16'h5A5A, 16'h0100, 16'h0100);
        send_request(FUNC_INSERT, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(FUNC_INSERT, 16'h7FFF, 16'h8000, 16'h0000);
        send_request(FUNC_SEARCH, 16'h0000, 16'h0000, 16'h0000);
        send_request(FUNC_SEARCH, 16'hFFFF, 16'h0000, 16'h0000);
        send_request(FUNC_SEARCH, 16'h5A5A, 16'h0000, 16'h0000);
        send_request(FUNC_SEARCH, 16'h0001, 16'h0000, 16'h0000);
    endtask

    // random mix of inserts and searches
    task automatic test_random_traffic(input int n_items, input int insert_pct);
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < insert_pct)
                send_request(FUNC_INSERT, pick_id(30), pick_weight(), pick_skill());
            else
                send_request(FUNC_SEARCH, pick_id(70), WEIGHT_W'($urandom), SKILL_W'($urandom));
        end
    endtask

    // top up the table, then refusals and searches at both ends
    task automatic test_full_table();
        while (shadow_fill < TBL_DEPTH)
            send_request(FUNC_INSERT, pick_id(30), WEIGHT_W'($urandom_range(16'hFFFF, 1)),
                         pick_skill());
        send_request(FUNC_INSERT, 16'h4321, 16'h0100, 16'h0200);
        send_request(FUNC_INSERT, 16'h4321, 16'h0000, 16'h0200);
        send_request(FUNC_SEARCH, shadow_slot[TBL_DEPTH-1].id, 16'h0000, 16'h0000);
        send_request(FUNC_SEARCH, shadow_slot[0].id, 16'h0000, 16'h0000);
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            got_result = {o_status, o_found_id, o_found_weight, o_found_skill,
                          o_found_ratio, o_rank};
            n_checked++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("unexpected result: status %0d id %h", o_status, o_found_id);
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.status !== want_result.status ||
                    got_result.id !== want_result.id ||
                    got_result.weight !== want_result.weight ||
                    got_result.skill !== want_result.skill ||
                    got_result.ratio !== want_result.ratio ||
                    got_result.rank !== want_result.rank) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS) begin
                        $display("mismatch: exp st %0d id %h w %h s %h ratio %h rank %0d",
                                 want_result.status, want_result.id, want_result.weight,
                                 want_result.skill, want_result.ratio, want_result.rank);
                        $display("          got st %0d id %h w %h s %h ratio %h rank %0d",
                                 got_result.status, got_result.id, got_result.weight,
                                 got_result.skill, got_result.ratio, got_result.rank);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("ratio_sorted_entry_table test failed");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles less than receiver
        send_idle_pct = 25;
        recv_idle_pct = 55;
        test_empty_table();
        test_key_order();
        wait_for_results();
        test_random_traffic(130, 50);
        wait_for_results();
        test_full_table();
        wait_for_results();

        // receiver idles less than sender
        send_idle_pct = 55;
        recv_idle_pct = 25;
        test_random_traffic(130, 30);
        wait_for_results();

        // back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(130, 30);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (pending_results.size() != 0) n_mismatch++;
        $display("covered %0d placed inserts, %0d refused as full, %0d refused for zero weight",
                 n_inserted, n_full, n_zero_wt);
        $display("%0d searches hit, %0d missed; %0d results checked, %0d mismatches",
                 n_hit, n_miss, n_checked, n_mismatch);
        if (n_mismatch == 0) begin
            $display("ratio_sorted_entry_table test passed");
        end else begin
            $display("ratio_sorted_entry_table test failed");
        end
        $finish;
    end

endmodule
